// ----- rtl/accel_tilt_level_estimator_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the tilt and level estimator controller.
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_LEVEL_ESTIMATOR_DEFINES_SVH
`define ACCEL_TILT_LEVEL_ESTIMATOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define ATL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define ATL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/atle_pkg.sv -----
// ---------------------------------------------------------------------------
// atle_pkg
// Types and constants shared by the tilt and level estimator modules.
// ---------------------------------------------------------------------------
`default_nettype none
package atle_pkg;

  localparam int AngleLimit = 23040;
  localparam int AtanEntries = 24;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegSampleCount = 2'd0;
  localparam logic [1:0] RegArmLength   = 2'd1;
  localparam logic [1:0] RegHingeOffset = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCUM,     // add sample, count it
    OP_CLEAR,     // drop batch
    OP_DIV_INIT,  // latch sums, start signed division
    OP_DIV_STEP,  // one quotient bit for all three axes
    OP_DIV_DONE,  // fix signs, clear sums
    OP_SQ,        // squares of the means, one axis per cycle
    OP_ISQ_INIT,  // load integer square root operand
    OP_ISQ_STEP,  // one root bit
    OP_COR_INIT,  // load CORDIC vectors
    OP_COR_STEP,  // one CORDIC rotation
    OP_COR_DONE,  // round and store angle
    OP_HDIV_INIT, // start y^2 * 2^32 / S
    OP_HDIV_STEP,
    OP_HEIGHT     // multiply, round, add offset, saturate
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;   // which angle or root operand is meant
  } cmd_t;

  typedef struct packed {
    logic batch_full;  // this sample completes the batch
    logic s_zero;      // squared magnitude is zero
    logic angle_zero;  // both atan2 arguments zero
  } stat_t;

  // atan(2^-i) in units of 2^-16 degree.
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0: v = 22'd2949120;  5'd1: v = 22'd1740967;  5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;   5'd4: v = 22'd234379;   5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;    5'd7: v = 22'd29335;    5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;     5'd10: v = 22'd3667;    5'd11: v = 22'd1833;
      5'd12: v = 22'd917;     5'd13: v = 22'd458;     5'd14: v = 22'd229;
      5'd15: v = 22'd115;     5'd16: v = 22'd57;      5'd17: v = 22'd29;
      5'd18: v = 22'd14;      5'd19: v = 22'd7;       5'd20: v = 22'd4;
      5'd21: v = 22'd2;       5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/atle_datapath.sv -----
// ---------------------------------------------------------------------------
// atle_datapath
// Accumulators, dividers, square root and CORDIC units for the
// estimator; every step is issued by the controller.
// ---------------------------------------------------------------------------
`default_nettype none
module atle_datapath
  import atle_pkg::*;
#(
  parameter int MAX_SAMPLES  = 256,
  parameter int SAMPLE_BITS  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  input  wire logic [4:0]             step,
  output stat_t                       stat,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_x,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_y,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_z,
  input  wire logic [8:0]             sample_count,
  input  wire logic [15:0]            arm_length,
  input  wire logic signed [15:0]     hinge_offset,
  output logic signed [15:0]          mean_x,
  output logic signed [15:0]          mean_y,
  output logic signed [15:0]          mean_z,
  output logic signed [15:0]          roll,
  output logic signed [15:0]          pitch,
  output logic signed [17:0]          height
);

  localparam int CntW = $clog2(MAX_SAMPLES + 1);
  localparam int SumW = SAMPLE_BITS + CntW;
  localparam int MW   = SAMPLE_BITS;
  localparam int SqW  = 2 * MW;            // one square
  localparam int S3W  = SqW + 2;           // sum of three squares
  localparam int NumW = SqW + 32;          // y^2 * 2^32
  localparam int RtW  = (S3W + 16) / 2 + 1;
  localparam int RadW = 2 * RtW;           // isqrt operand
  localparam int CW   = MW + 8 + 4;        // CORDIC vector width
  localparam int ZW   = 24;

  logic signed [SumW-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic [CntW-1:0]        taken_r;
  logic [SumW-1:0]        dq_r [3];
  logic [SumW-1:0]        drem_r [3];
  logic [2:0]             dneg_r;
  logic signed [MW-1:0]   mx_r, my_r, mz_r;
  logic [SqW-1:0]         x2_r, y2_r, z2_r;
  logic [RadW-1:0]        rn_r, rres_r, rbit_r;
  logic [RtW-1:0]         root_r [3];
  logic signed [CW-1:0]   cx_r, cy_r;
  logic signed [ZW-1:0]   cz_r;
  logic signed [15:0]     roll_r, pitch_r;
  logic [NumW-1:0]        hq_r, hrem_r;
  logic signed [17:0]     height_r;

  logic [CntW-1:0] need;
  logic [CntW:0]   cnt_ext;
  always_comb begin
    if (sample_count == 9'd0) need = CntW'(1);
    else if ({23'd0, sample_count} > MAX_SAMPLES) need = CntW'(MAX_SAMPLES);
    else need = CntW'(sample_count);
    cnt_ext = {1'b0, taken_r} + 1'b1;
  end

  logic [S3W-1:0] s_sum;
  assign s_sum = S3W'(x2_r) + S3W'(y2_r) + S3W'(z2_r);

  assign stat.batch_full = (cnt_ext >= {1'b0, need});
  assign stat.s_zero     = (s_sum == '0);
  assign stat.angle_zero = (cmd.sel == 2'd0) ? (mx_r == '0 && y2_r == '0 && z2_r == '0)
                                             : (my_r == '0 && x2_r == '0 && z2_r == '0);

  // Root operand: b2 << 16 for angles, w for the height.
  logic [RadW-1:0] isq_in;
  always_comb begin
    case (cmd.sel)
      2'd0:    isq_in = RadW'({(S3W'(y2_r) + S3W'(z2_r)), 16'd0});
      2'd1:    isq_in = RadW'({(S3W'(x2_r) + S3W'(z2_r)), 16'd0});
      default: isq_in = RadW'(hq_r);
    endcase
  end

  // Division step helpers (restoring, one bit per cycle).
  logic [SumW:0]   dsh [3];
  logic [NumW:0]   hsh;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsh[k] = {drem_r[k], dq_r[k][SumW-1]};
    end
    hsh = {hrem_r, hq_r[NumW-1]};
  end

  // CORDIC step helpers.
  logic signed [CW-1:0] dx, dy;
  logic [21:0]          at;
  assign dx = cy_r >>> step;
  assign dy = cx_r >>> step;
  assign at = atan_lut(step);

  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] ang;
  assign zr  = cz_r + ZW'(128);
  always_comb begin
    ang = -(zr >>> 8);
    if (ang > ZW'(AngleLimit)) ang = ZW'(AngleLimit);
    if (ang < -ZW'(AngleLimit)) ang = -ZW'(AngleLimit);
  end

  // Height.
  logic [15+RtW:0]  hprod;
  logic signed [19:0] hval, hsum;
  assign hprod = (16+RtW)'(arm_length) * (16+RtW)'(root_r[2]);
  always_comb begin
    hval = 20'(((hprod + (16+RtW)'(32768)) >> 16));
    if (stat.s_zero) hval = '0;
    else if (my_r > 0) hval = -hval;
    hsum = 20'(hinge_offset) + hval;
    if (hsum > 20'sd131071) hsum = 20'sd131071;
    if (hsum < -20'sd131072) hsum = -20'sd131072;
  end

  logic [SumW-1:0] absv [3];
  always_comb begin
    absv[0] = sum_x_r[SumW-1] ? SumW'(-sum_x_r) : SumW'(sum_x_r);
    absv[1] = sum_y_r[SumW-1] ? SumW'(-sum_y_r) : SumW'(sum_y_r);
    absv[2] = sum_z_r[SumW-1] ? SumW'(-sum_z_r) : SumW'(sum_z_r);
  end

  logic signed [MW-1:0] sq_a;
  always_comb begin
    case (step[1:0])
      2'd0:    sq_a = mx_r;
      2'd1:    sq_a = my_r;
      default: sq_a = mz_r;
    endcase
  end
  logic signed [SqW-1:0] sq_e;
  logic [SqW-1:0] sq_v;
  assign sq_e = SqW'(sq_a);
  assign sq_v = SqW'(sq_e * sq_e);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      taken_r <= '0;
    end else begin
      case (cmd.op)
        OP_ACCUM: begin
          sum_x_r <= sum_x_r + SumW'(smp_x);
          sum_y_r <= sum_y_r + SumW'(smp_y);
          sum_z_r <= sum_z_r + SumW'(smp_z);
          taken_r <= CntW'(cnt_ext);
        end
        OP_CLEAR: begin
          sum_x_r <= '0;
          sum_y_r <= '0;
          sum_z_r <= '0;
          taken_r <= '0;
        end
        OP_DIV_INIT: begin
          for (int k = 0; k < 3; k++) begin
            dq_r[k]   <= absv[k];
            drem_r[k] <= '0;
          end
          dneg_r <= {sum_z_r[SumW-1], sum_y_r[SumW-1], sum_x_r[SumW-1]};
        end
        OP_DIV_STEP: begin
          for (int k = 0; k < 3; k++) begin
            if (dsh[k] >= (SumW+1)'(taken_r)) begin
              drem_r[k] <= SumW'(dsh[k] - (SumW+1)'(taken_r));
              dq_r[k]   <= {dq_r[k][SumW-2:0], 1'b1};
            end else begin
              drem_r[k] <= SumW'(dsh[k]);
              dq_r[k]   <= {dq_r[k][SumW-2:0], 1'b0};
            end
          end
        end
        OP_DIV_DONE: begin
          mx_r <= MW'(dneg_r[0] ? -dq_r[0] : dq_r[0]);
          my_r <= MW'(dneg_r[1] ? -dq_r[1] : dq_r[1]);
          mz_r <= MW'(dneg_r[2] ? -dq_r[2] : dq_r[2]);
          sum_x_r <= '0;
          sum_y_r <= '0;
          sum_z_r <= '0;
          taken_r <= '0;
        end
        OP_SQ: begin
          case (step[1:0])
            2'd0:    x2_r <= sq_v;
            2'd1:    y2_r <= sq_v;
            default: z2_r <= sq_v;
          endcase
        end
        OP_ISQ_INIT: begin
          rn_r   <= isq_in;
          rres_r <= '0;
          rbit_r <= RadW'(1) << (RadW - 2);
        end
        OP_ISQ_STEP: begin
          if (rn_r >= rres_r + rbit_r) begin
            rn_r   <= rn_r - (rres_r + rbit_r);
            rres_r <= (rres_r >> 1) + rbit_r;
          end else begin
            rres_r <= rres_r >> 1;
          end
          rbit_r <= rbit_r >> 2;
          if (rbit_r == RadW'(1))
            root_r[cmd.sel] <= (rn_r >= rres_r + rbit_r) ?
                               RtW'((rres_r >> 1) + rbit_r) : RtW'(rres_r >> 1);
        end
        OP_COR_INIT: begin
          cx_r <= CW'(root_r[cmd.sel]);
          cy_r <= (cmd.sel == 2'd0) ? CW'($signed({mx_r, 8'd0}))
                                    : CW'($signed({my_r, 8'd0}));
          cz_r <= '0;
        end
        OP_COR_STEP: begin
          if (cy_r >= 0) begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            cz_r <= cz_r + ZW'(at);
          end else begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            cz_r <= cz_r - ZW'(at);
          end
        end
        OP_COR_DONE: begin
          if (cmd.sel == 2'd0) roll_r <= stat.angle_zero ? 16'sd0 : 16'(ang);
          else pitch_r <= stat.angle_zero ? 16'sd0 : 16'(ang);
        end
        OP_HDIV_INIT: begin
          hq_r   <= {y2_r, 32'd0};
          hrem_r <= '0;
        end
        OP_HDIV_STEP: begin
          if (hsh >= (NumW+1)'(s_sum)) begin
            hrem_r <= NumW'(hsh - (NumW+1)'(s_sum));
            hq_r   <= {hq_r[NumW-2:0], 1'b1};
          end else begin
            hrem_r <= NumW'(hsh);
            hq_r   <= {hq_r[NumW-2:0], 1'b0};
          end
        end
        OP_HEIGHT: height_r <= 18'(hsum);
        default: ;
      endcase
    end
  end

  assign mean_x = mx_r;
  assign mean_y = my_r;
  assign mean_z = mz_r;
  assign roll   = roll_r;
  assign pitch  = pitch_r;
  assign height = height_r;

endmodule
`default_nettype wire

// ----- rtl/atle_ctrl.sv -----
// ---------------------------------------------------------------------------
// atle_ctrl
// Sequencer for the estimator: takes samples, then walks the datapath
// through division, roots, CORDIC and height, and holds the result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "accel_tilt_level_estimator_defines.svh"
module atle_ctrl
  import atle_pkg::*;
#(
  parameter int SUM_BITS   = 25,
  parameter int ROOT_STEPS = 25,
  parameter int HDIV_BITS  = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic in_read_error,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd,
  output logic [4:0] step,
  input  wire stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_INIT, S_DIV, S_DIV_DONE, S_SQ, S_ISQ_INIT, S_ISQ,
    S_COR_INIT, S_COR, S_COR_DONE, S_HDIV_INIT, S_HDIV, S_HEIGHT
  } state_t;

  state_t      state_r;
  logic [6:0]  cnt_r;
  logic [1:0]  sel_r;
  logic        out_valid_r;

  logic take;
  // Samples that leave the batch open are taken while a result is held; only a
  // sample that would start a new computation waits for the result transaction.
  assign in_ready = (state_r == S_IDLE) && !(out_valid_r && stat.batch_full);
  assign take     = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign step = cnt_r[4:0];

  always_comb begin
    cmd.sel = sel_r;
    case (state_r)
      S_IDLE:      cmd.op = take ? (in_read_error ? OP_CLEAR : OP_ACCUM) : OP_NONE;
      S_DIV_INIT:  cmd.op = OP_DIV_INIT;
      S_DIV:       cmd.op = OP_DIV_STEP;
      S_DIV_DONE:  cmd.op = OP_DIV_DONE;
      S_SQ:        cmd.op = OP_SQ;
      S_ISQ_INIT:  cmd.op = OP_ISQ_INIT;
      S_ISQ:       cmd.op = OP_ISQ_STEP;
      S_COR_INIT:  cmd.op = OP_COR_INIT;
      S_COR:       cmd.op = OP_COR_STEP;
      S_COR_DONE:  cmd.op = OP_COR_DONE;
      S_HDIV_INIT: cmd.op = OP_HDIV_INIT;
      S_HDIV:      cmd.op = OP_HDIV_STEP;
      S_HEIGHT:    cmd.op = OP_HEIGHT;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE:
          if (take && !in_read_error && stat.batch_full) state_r <= S_DIV_INIT;
        S_DIV_INIT: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'(SUM_BITS - 1)) state_r <= S_DIV_DONE;
        end
        S_DIV_DONE: begin
          cnt_r   <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'd2) begin
            sel_r   <= 2'd0;
            state_r <= S_ISQ_INIT;
          end
        end
        S_ISQ_INIT: begin
          cnt_r   <= '0;
          state_r <= S_ISQ;
        end
        S_ISQ: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'(ROOT_STEPS - 1))
            state_r <= (sel_r == 2'd2) ? S_HEIGHT : S_COR_INIT;
        end
        S_COR_INIT: begin
          cnt_r   <= '0;
          state_r <= S_COR;
        end
        S_COR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'(CORDIC_STEPS - 1)) state_r <= S_COR_DONE;
        end
        S_COR_DONE: begin
          if (sel_r == 2'd0) begin
            sel_r   <= 2'd1;
            state_r <= S_ISQ_INIT;
          end else begin
            sel_r   <= 2'd2;
            state_r <= S_HDIV_INIT;
          end
        end
        S_HDIV_INIT: begin
          cnt_r   <= '0;
          state_r <= S_HDIV;
        end
        S_HDIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'(HDIV_BITS - 1)) state_r <= S_ISQ_INIT;
        end
        S_HEIGHT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ATL_ASSERT_IMP(a_no_take_busy, clk, rst_n, state_r != S_IDLE, !in_ready,
                  "sample taken while busy")
  `ATL_ASSERT_NXT(a_result_hold, clk, rst_n, out_valid && !out_ready, out_valid,
                  "result dropped before transaction")
  `ATL_ASSERT_NXT(a_height_emits, clk, rst_n, state_r == S_HEIGHT, out_valid,
                  "finished batch not presented")

endmodule
`default_nettype wire

// ----- rtl/accel_tilt_level_estimator.sv -----
// A sample that completes a batch starts the computation: the divide, the
// squares, a root and CORDIC run for roll and then for pitch, the height
// divide, the height root and the height itself; the result is then held.
// While idle, other samples are taken one per cycle; a completing sample waits
// while an earlier result is still held. Shared bit-serial units set the rate.
// Reset is synchronous, active low; it clears the batch and resets the configuration registers.
// ---------------------------------------------------------------------------
// accel_tilt_level_estimator
// Averages accelerometer batches and gives the means, roll, pitch and a signed height.
// ---------------------------------------------------------------------------
`default_nettype none
module accel_tilt_level_estimator
  import atle_pkg::*;
#(
  parameter int MAX_SAMPLES  = 256,
  parameter int SAMPLE_BITS  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_y,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_z,
  input  wire logic        in_read_error,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_mean_x,
  output logic signed [15:0] out_mean_y,
  output logic signed [15:0] out_mean_z,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [17:0] out_level_height,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CntW = $clog2(MAX_SAMPLES + 1);
  localparam int SumW = SAMPLE_BITS + CntW;
  localparam int RtW  = (2 * SAMPLE_BITS + 2 + 16) / 2 + 1;

  logic [8:0]         cnt_r;
  logic [15:0]        arm_r;
  logic signed [15:0] off_r;
  cmd_t  cmd;
  stat_t stat;
  logic [4:0] step;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 9'd1;
      arm_r <= '0;
      off_r <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        RegSampleCount: cnt_r <= pwdata[8:0];
        RegArmLength:   arm_r <= pwdata[15:0];
        RegHingeOffset: off_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegSampleCount: prdata = {23'd0, cnt_r};
      RegArmLength:   prdata = {16'd0, arm_r};
      RegHingeOffset: prdata = {{16{off_r[15]}}, off_r};
      default:        prdata = '0;
    endcase
  end

  atle_ctrl #(
    .SUM_BITS(SumW), .ROOT_STEPS(RtW), .HDIV_BITS(2 * SAMPLE_BITS + 32),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_read_error,
    .out_valid, .out_ready, .cmd, .step, .stat
  );

  atle_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk, .rst_n, .cmd, .step, .stat,
    .smp_x(in_sample_x), .smp_y(in_sample_y), .smp_z(in_sample_z),
    .sample_count(cnt_r), .arm_length(arm_r), .hinge_offset(off_r),
    .mean_x(out_mean_x), .mean_y(out_mean_y), .mean_z(out_mean_z),
    .roll(out_roll_angle), .pitch(out_pitch_angle), .height(out_level_height)
  );

endmodule
`default_nettype wire
